// ===== hdl/ccss_pkg.sv =====
// Shared types and constants for the crystal clock source supervisor.
// Used by the top level and by the serial divider; depends on nothing.
`default_nettype none

package ccss_pkg;

	localparam int unsigned RC_SAMPLES_DEF = 100;

	localparam int unsigned RC_W     = 16;
	localparam int unsigned PERIOD_W = 32;
	localparam int unsigned FREQ_W   = 39;
	localparam int unsigned RETRY_W  = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// 2^19 * 10^6
	localparam logic [FREQ_W-1:0] FREQ_NUM = 39'd524288000000;

	localparam logic              SW_EN_RST      = 1'b1;
	localparam logic              START_XTAL_RST = 1'b0;
	localparam logic [RC_W-1:0]   RC_MIN_RST     = 16'd48;
	localparam logic [PERIOD_W-1:0] PER_MIN_RST  = 32'd15200000;
	localparam logic [PERIOD_W-1:0] PER_MAX_RST  = 32'd16800000;
	localparam logic [RETRY_W-1:0]  RETRY_RST    = 8'd10;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_RC    = 2'd1;
	localparam logic [1:0] FUNC_CAL   = 2'd2;

	localparam logic [2:0] ACT_IGNORE  = 3'd0;
	localparam logic [2:0] ACT_SAMPLE  = 3'd1;
	localparam logic [2:0] ACT_XCAL    = 3'd2;
	localparam logic [2:0] ACT_APPLY   = 3'd3;
	localparam logic [2:0] ACT_XMEAS   = 3'd4;
	localparam logic [2:0] ACT_TO_INT  = 3'd5;
	localparam logic [2:0] ACT_INT_CAL = 3'd6;
	localparam logic [2:0] ACT_FINISH  = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_SW_EN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_XTAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RC_MIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_MIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_MAX    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY      = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SAMPLE,
		PH_XCAL,
		PH_XMEAS,
		PH_ICAL,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		CT_READY,
		CT_EVAL,
		CT_DIV,
		CT_FIN
	} ctrl_t;

	typedef struct packed {
		logic [1:0]          func;
		logic [RC_W-1:0]     rc_time_us;
		logic [PERIOD_W-1:0] cal_period;
	} item_t;

	typedef struct packed {
		logic [2:0]          action;
		logic                bootstrap;
		logic [PERIOD_W-1:0] apply_period;
		logic [FREQ_W-1:0]   freq_hz;
		logic                resistor_valid;
		logic                clock_source;
		logic [RC_W-1:0]     avg_rc_us;
		logic                done_res;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/ccss_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ccss_pkg for default widths.
`default_nettype none

module ccss_div
	import ccss_pkg::*;
#(
	parameter int unsigned DVD_W = FREQ_W,
	parameter int unsigned DVS_W = PERIOD_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic [DVD_W-1:0]      quotient
);

	localparam int unsigned STEP_W = $clog2(DVD_W + 1);

	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [DVS_W-1:0]   dvs_q;
	logic [DVS_W-1:0]   rem_q;

	logic [DVS_W:0]     trial;
	logic [DVS_W:0]     diff;
	logic               qbit;

	// dividend bits leave at the top while quotient bits enter at the bottom
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DVD_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

// ===== hdl/crystal_clock_source_supervisor.sv =====
// Slow clock source supervisor: event sequencer, config registers, result register.
// Depends on ccss_pkg and ccss_div.
//
//   channel   | handshake           | payload
//   ----------+---------------------+---------------------------
//   item      | item_valid/stall    | item   (func, rc, period)
//   result    | result_valid/stall  | result (action ... done)
//   config    | cfg_valid/ready     | cfg_index, cfg_data
//
// The result register is loaded in the FIN state that follows the EVAL state, once
// the result output is free, and the input opens again the cycle after. The last
// RC sample and a non-zero crystal re-measure also pass the DIV state, for
// DVD_W (39) quotient bits, one a cycle in the shared serial divider, until the
// divider drops busy. One event is in work at a time; a new one is taken while
// the previous result waits, and is then held until the result register frees.
// Async reset loads the listed values, no clearing pass; item/result data are not reset.
`default_nettype none

module crystal_clock_source_supervisor
	import ccss_pkg::*;
#(
	parameter int unsigned RC_SAMPLES = RC_SAMPLES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned ACC_W = RC_W + $clog2(RC_SAMPLES);
	localparam int unsigned CNT_W = $clog2(RC_SAMPLES + 1);

	// configuration
	logic                sw_en_q;
	logic [RC_W-1:0]     rc_min_q;
	logic [PERIOD_W-1:0] per_min_q;
	logic [PERIOD_W-1:0] per_max_q;
	logic [RETRY_W-1:0]  retry_lim_q;

	// supervision state
	phase_t              ph_q, ph_nxt;
	logic                src_q, src_nxt;
	logic [CNT_W-1:0]    cnt_q, cnt_nxt, cnt_inc;
	logic [ACC_W-1:0]    acc_q, acc_nxt, sum;
	logic [RETRY_W-1:0]  ret_q, ret_nxt;
	logic [FREQ_W-1:0]   freq_q, freq_nxt, freq_new;
	logic                rvalid_q, rvalid_nxt;
	logic [RC_W-1:0]     avg_q, avg_nxt;

	ctrl_t               ctrl_q, ctrl_nxt;
	item_t               item_q;
	logic                res_vld_q;
	result_t             res_q, res_nxt;

	logic                need_avg, need_hz, need_div;
	logic                div_start, div_busy, fin_load, out_free;
	logic [FREQ_W-1:0]   div_dvd, quo;
	logic [PERIOD_W-1:0] div_dvs;
	logic [2:0]          act;
	logic                boot;
	logic [PERIOD_W-1:0] cal;

	ccss_div #(
		.DVD_W (FREQ_W),
		.DVS_W (PERIOD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_comb begin
		sum     = acc_q + ACC_W'(item_q.rc_time_us);
		cnt_inc = cnt_q + CNT_W'(1);
		need_avg = (ph_q == PH_SAMPLE) && (item_q.func == FUNC_RC)
			&& (cnt_inc == CNT_W'(RC_SAMPLES));
		need_hz  = (ph_q == PH_XMEAS) && (item_q.func == FUNC_CAL)
			&& (item_q.cal_period != '0);
		need_div = need_avg || need_hz;
		div_dvd  = need_avg ? FREQ_W'(sum) : FREQ_NUM;
		div_dvs  = need_avg ? PERIOD_W'(RC_SAMPLES) : item_q.cal_period;
		out_free = !res_vld_q || !result_stall;
	end

	// control sequencer: next state
	always_comb begin
		ctrl_nxt = ctrl_q;
		case (ctrl_q)
			CT_READY: if (item_valid) ctrl_nxt = CT_EVAL;
			CT_EVAL:  ctrl_nxt = need_div ? CT_DIV : CT_FIN;
			CT_DIV:   if (!div_busy) ctrl_nxt = CT_FIN;
			CT_FIN:   if (out_free) ctrl_nxt = CT_READY;
			default:  ctrl_nxt = CT_READY;
		endcase
	end

	// control sequencer: outputs
	always_comb begin
		item_stall = 1'b1;
		div_start  = 1'b0;
		fin_load   = 1'b0;
		case (ctrl_q)
			CT_READY: item_stall = 1'b0;
			CT_EVAL:  div_start  = need_div;
			CT_DIV:   ;
			CT_FIN:   fin_load   = out_free;
			default:  ;
		endcase
	end

	// event evaluation, committed when the result is loaded
	always_comb begin
		ph_nxt     = ph_q;
		src_nxt    = src_q;
		cnt_nxt    = cnt_q;
		acc_nxt    = acc_q;
		ret_nxt    = ret_q;
		freq_nxt   = freq_q;
		rvalid_nxt = rvalid_q;
		avg_nxt    = avg_q;
		act        = ACT_IGNORE;
		boot       = 1'b0;
		cal        = '0;
		freq_new   = (item_q.cal_period == '0) ? '0 : quo;
		case (ph_q)
			PH_IDLE: begin
				if (item_q.func == FUNC_START) begin
					if (!sw_en_q) begin
						ph_nxt = PH_DONE;
						act    = ACT_FINISH;
					end else begin
						cnt_nxt = '0;
						acc_nxt = '0;
						ph_nxt  = PH_SAMPLE;
						act     = ACT_SAMPLE;
					end
				end
			end
			PH_SAMPLE: begin
				if (item_q.func == FUNC_RC) begin
					acc_nxt = sum;
					cnt_nxt = cnt_inc;
					if (!need_avg) begin
						act = ACT_SAMPLE;
					end else begin
						avg_nxt    = quo[RC_W-1:0];
						rvalid_nxt = (quo[RC_W-1:0] > rc_min_q);
						if (!(quo[RC_W-1:0] > rc_min_q)) begin
							ph_nxt = PH_DONE;
							act    = ACT_FINISH;
						end else if (src_q) begin
							src_nxt = 1'b0;
							ret_nxt = retry_lim_q;
							ph_nxt  = PH_XCAL;
							act     = ACT_XCAL;
						end else begin
							ph_nxt = PH_XMEAS;
							act    = ACT_XMEAS;
						end
					end
				end
			end
			PH_XCAL: begin
				if (item_q.func == FUNC_CAL) begin
					if ((item_q.cal_period > per_min_q) && (item_q.cal_period < per_max_q)) begin
						cal    = item_q.cal_period;
						ph_nxt = PH_XMEAS;
						act    = ACT_APPLY;
					end else begin
						boot = (item_q.cal_period == '0);
						if (ret_q != '0) begin
							ret_nxt = ret_q - RETRY_W'(1);
							act     = ACT_XCAL;
						end else begin
							freq_nxt = '0;
							src_nxt  = 1'b1;
							ph_nxt   = PH_ICAL;
							act      = ACT_TO_INT;
						end
					end
				end
			end
			PH_XMEAS: begin
				if (item_q.func == FUNC_CAL) begin
					freq_nxt = freq_new;
					if (freq_new == '0) begin
						src_nxt = 1'b1;
						ph_nxt  = PH_ICAL;
						act     = ACT_TO_INT;
					end else begin
						ph_nxt = PH_DONE;
						act    = ACT_FINISH;
					end
				end
			end
			PH_ICAL: begin
				if (item_q.func == FUNC_CAL) begin
					cal    = item_q.cal_period;
					ph_nxt = PH_DONE;
					act    = ACT_INT_CAL;
				end
			end
			default: ;
		endcase

		res_nxt.action         = act;
		res_nxt.bootstrap      = boot;
		res_nxt.apply_period   = cal;
		res_nxt.freq_hz        = freq_nxt;
		res_nxt.resistor_valid = rvalid_nxt;
		res_nxt.clock_source   = src_nxt;
		res_nxt.avg_rc_us      = avg_nxt;
		res_nxt.done_res       = (ph_nxt == PH_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q       <= CT_READY;
			res_vld_q    <= 1'b0;
			sw_en_q      <= SW_EN_RST;
			rc_min_q     <= RC_MIN_RST;
			per_min_q    <= PER_MIN_RST;
			per_max_q    <= PER_MAX_RST;
			retry_lim_q  <= RETRY_RST;
			ph_q         <= PH_IDLE;
			src_q        <= ~START_XTAL_RST;
			cnt_q        <= '0;
			acc_q        <= '0;
			ret_q        <= '0;
			freq_q       <= '0;
			rvalid_q     <= 1'b0;
			avg_q        <= '0;
		end else begin
			ctrl_q <= ctrl_nxt;
			if (fin_load) begin
				res_vld_q <= 1'b1;
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end

			if (fin_load) begin
				ph_q     <= ph_nxt;
				src_q    <= src_nxt;
				cnt_q    <= cnt_nxt;
				acc_q    <= acc_nxt;
				ret_q    <= ret_nxt;
				freq_q   <= freq_nxt;
				rvalid_q <= rvalid_nxt;
				avg_q    <= avg_nxt;
			end

			// writes must arrive only while no event is in work; the block does not enforce it
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SW_EN:      sw_en_q <= cfg_data[0];
					CFG_START_XTAL: begin
						if (ph_q == PH_IDLE) src_q <= ~cfg_data[0];
					end
					CFG_RC_MIN:     rc_min_q    <= cfg_data[RC_W-1:0];
					CFG_PER_MIN:    per_min_q   <= cfg_data[PERIOD_W-1:0];
					CFG_PER_MAX:    per_max_q   <= cfg_data[PERIOD_W-1:0];
					CFG_RETRY:      retry_lim_q <= cfg_data[RETRY_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_q <= item;
		end
		if (fin_load) begin
			res_q <= res_nxt;
		end
	end

	assign cfg_ready    = 1'b1;
	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

`default_nettype wire
